/* rtl/core/triangle_normal_color_expand_unit_defines.svh */
// Assertion macros shared by the triangle normal color expand RTL
`ifndef TRIANGLE_NORMAL_COLOR_EXPAND_UNIT_DEFINES_SVH
`define TRIANGLE_NORMAL_COLOR_EXPAND_UNIT_DEFINES_SVH

// Antecedent holds, so the consequent holds in the same cycle
`define TNCE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tnce check failed");

// Antecedent holds, so the consequent holds in the next cycle
`define TNCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tnce check failed");

`endif

/* rtl/core/tnce_pkg.sv */
// Package: types, constants and step functions of the normal color expand unit
package tnce_pkg;

  localparam int NB       = 24;                // normal component width
  localparam int SUM_W    = 2 * NB;            // sum of squares width
  localparam int SQ_PAIRS = (NB + 1) / 2;      // square root cycles, two digits each
  localparam int RT_W     = 2 * SQ_PAIRS;      // root register width
  localparam int REM_W    = RT_W + 1;          // root remainder width
  localparam int SH_W     = 4 * SQ_PAIRS;      // radicand shift register width
  localparam int DN_W     = NB + 9;            // divider numerator width
  localparam int CNT_W    = $clog2(SQ_PAIRS);  // engine step counter width
  localparam int DIV_CYC  = 4;                 // eight quotient bits, two per cycle

  localparam logic [7:0] ALPHA   = 8'hFF;
  localparam logic [7:0] MID_CH  = 8'd127;
  localparam logic [1:0] VC_LAST = 2'd2;

  typedef struct packed {
    logic signed [NB-1:0] normal_x;
    logic signed [NB-1:0] normal_y;
    logic signed [NB-1:0] normal_z;
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] first_z;
    logic [31:0] second_x;
    logic [31:0] second_y;
    logic [31:0] second_z;
    logic [31:0] third_x;
    logic [31:0] third_y;
    logic [31:0] third_z;
  } tnce_in_t;

  typedef struct packed {
    logic [31:0] packed_color;
    logic signed [NB-1:0] out_normal_x;
    logic signed [NB-1:0] out_normal_y;
    logic signed [NB-1:0] out_normal_z;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic        last_vertex;
  } tnce_out_t;

  // Queue entry: triangle plus the squared length of its normal
  typedef struct packed {
    tnce_in_t         tri_data;
    logic [SUM_W-1:0] sum;
  } tnce_qent_t;

  typedef struct packed {
    logic [RT_W-1:0]  root;
    logic [REM_W-1:0] rem;
  } sq_acc_t;

  typedef struct packed {
    logic [7:0]      q;
    logic [DN_W-1:0] rem;
  } dv_acc_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQRT,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  // One restoring square root digit
  function automatic sq_acc_t sq_step(sq_acc_t a, logic [1:0] pair);
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] trial;
    sq_acc_t o;
    r2    = {a.rem, pair};
    trial = {1'b0, a.root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = REM_W'(r2 - trial);
      o.root = {a.root[RT_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(r2);
      o.root = {a.root[RT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // One restoring division bit against a pre-shifted divisor
  function automatic dv_acc_t div_step(dv_acc_t a, logic [DN_W-1:0] ds);
    dv_acc_t o;
    if (a.rem >= ds) begin
      o.rem = a.rem - ds;
      o.q   = {a.q[6:0], 1'b1};
    end else begin
      o.rem = a.rem;
      o.q   = {a.q[6:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* rtl/core/tnce_front.sv */
// Front stage: takes triangles, squares the normal components, feeds the queue
module tnce_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tnce_pkg::tnce_in_t   in_data,
  output logic                 q_valid,
  input  logic                 q_ready,
  output tnce_pkg::tnce_qent_t q_data
);

  logic                        fv_r;
  tnce_pkg::tnce_in_t          fb_r;
  logic [tnce_pkg::SUM_W-1:0]  sq_r [3];
  logic signed [tnce_pkg::SUM_W-1:0] px, py, pz;

  assign in_ready = !fv_r || q_ready;

  // signed squares, always non-negative
  always_comb begin
    px = in_data.normal_x * in_data.normal_x;
    py = in_data.normal_y * in_data.normal_y;
    pz = in_data.normal_z * in_data.normal_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fb_r     <= in_data;
      sq_r[0]  <= unsigned'(px);
      sq_r[1]  <= unsigned'(py);
      sq_r[2]  <= unsigned'(pz);
    end
  end

  // sum of squares cannot overflow SUM_W bits
  assign q_valid         = fv_r;
  assign q_data.tri_data = fb_r;
  assign q_data.sum      = sq_r[0] + sq_r[1] + sq_r[2];

endmodule

/* rtl/core/tnce_queue.sv */
// Two-entry queue between the front and the back
module tnce_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  tnce_pkg::tnce_qent_t wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output tnce_pkg::tnce_qent_t rd_data
);

  tnce_pkg::tnce_qent_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/core/tnce_back.sv */
// Back stage: square root and divider engine, then three-vertex output register
module tnce_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  tnce_pkg::tnce_qent_t q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tnce_pkg::tnce_out_t  out_data
);

  tnce_pkg::bk_state_t         st_r, st_nxt;
  tnce_pkg::tnce_qent_t        ent_r, ent_nxt;
  logic [tnce_pkg::SH_W-1:0]   sh_r, sh_nxt;
  tnce_pkg::sq_acc_t           acc_r, acc_nxt;
  tnce_pkg::dv_acc_t           dacc_r [3];
  tnce_pkg::dv_acc_t           dacc_nxt [3];
  logic [tnce_pkg::DN_W-1:0]   ds_r, ds_nxt;
  logic [tnce_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        zero_r, zero_nxt;
  logic                        load_emit;

  // output register
  logic                        ev_r;
  tnce_pkg::tnce_in_t          eb_r;
  logic [31:0]                 col_r;
  logic [1:0]                  vc_r;
  logic                        out_fire, emit_free;
  logic [31:0]                 col_nxt;

  tnce_pkg::sq_acc_t           s1;
  tnce_pkg::dv_acc_t           d1;
  logic signed [tnce_pkg::NB-1:0] nrm [3];
  logic [tnce_pkg::NB-1:0]     len;
  logic signed [tnce_pkg::NB+1:0] av;
  logic [tnce_pkg::DN_W-1:0]   aw;

  assign out_fire  = ev_r && out_ready;
  assign emit_free = !ev_r || (out_fire && (vc_r == tnce_pkg::VC_LAST));

  always_comb begin
    nrm[0] = ent_r.tri_data.normal_x;
    nrm[1] = ent_r.tri_data.normal_y;
    nrm[2] = ent_r.tri_data.normal_z;
    len    = acc_r.root[tnce_pkg::NB-1:0];
  end

  // engine next state and datapath
  always_comb begin
    st_nxt    = st_r;
    ent_nxt   = ent_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    ds_nxt    = ds_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    dacc_nxt  = dacc_r;
    load_emit = 1'b0;
    q_ready   = 1'b0;
    s1        = acc_r;
    d1        = dacc_r[0];
    av        = '0;
    aw        = '0;
    case (st_r)
      tnce_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          ent_nxt = q_data;
          sh_nxt  = tnce_pkg::SH_W'(q_data.sum);
          acc_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = tnce_pkg::BK_SQRT;
        end
      end
      tnce_pkg::BK_SQRT: begin
        // two root digits per cycle
        s1      = tnce_pkg::sq_step(acc_r, sh_r[tnce_pkg::SH_W-1 -: 2]);
        acc_nxt = tnce_pkg::sq_step(s1, sh_r[tnce_pkg::SH_W-3 -: 2]);
        sh_nxt  = sh_r << 4;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tnce_pkg::CNT_W'(tnce_pkg::SQ_PAIRS - 1)) begin
          cnt_nxt = '0;
          st_nxt  = tnce_pkg::BK_PREP;
        end
      end
      tnce_pkg::BK_PREP: begin
        // numerator 255*(n+len), divisor 2*len aligned to quotient bit 7
        for (int c = 0; c < 3; c++) begin
          av = {nrm[c][tnce_pkg::NB-1], nrm[c][tnce_pkg::NB-1], nrm[c]} +
               {2'b00, len};
          aw = tnce_pkg::DN_W'(av[tnce_pkg::NB:0]);
          dacc_nxt[c].rem = (aw << 8) - aw;
          dacc_nxt[c].q   = '0;
        end
        ds_nxt   = tnce_pkg::DN_W'({len, 1'b0}) << 7;
        zero_nxt = (len == '0);
        cnt_nxt  = '0;
        st_nxt   = tnce_pkg::BK_DIV;
      end
      tnce_pkg::BK_DIV: begin
        for (int c = 0; c < 3; c++) begin
          d1          = tnce_pkg::div_step(dacc_r[c], ds_r);
          dacc_nxt[c] = tnce_pkg::div_step(d1, ds_r >> 1);
        end
        ds_nxt  = ds_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tnce_pkg::CNT_W'(tnce_pkg::DIV_CYC - 1)) begin
          cnt_nxt = '0;
          st_nxt  = tnce_pkg::BK_DONE;
        end
      end
      tnce_pkg::BK_DONE: begin
        if (emit_free) begin
          load_emit = 1'b1;
          st_nxt    = tnce_pkg::BK_IDLE;
        end
      end
      default: begin
        st_nxt = tnce_pkg::BK_IDLE;
      end
    endcase
  end

  assign col_nxt = zero_r ?
      {tnce_pkg::ALPHA, tnce_pkg::MID_CH, tnce_pkg::MID_CH, tnce_pkg::MID_CH} :
      {tnce_pkg::ALPHA, dacc_r[2].q, dacc_r[1].q, dacc_r[0].q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tnce_pkg::BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    sh_r   <= sh_nxt;
    acc_r  <= acc_nxt;
    ds_r   <= ds_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
    dacc_r <= dacc_nxt;
  end

  // output register: one triangle, three vertex transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
      vc_r <= 2'd0;
    end else if (load_emit) begin
      ev_r <= 1'b1;
      vc_r <= 2'd0;
    end else if (out_fire) begin
      if (vc_r == tnce_pkg::VC_LAST) begin
        ev_r <= 1'b0;
      end else begin
        vc_r <= vc_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_emit) begin
      eb_r  <= ent_r.tri_data;
      col_r <= col_nxt;
    end
  end

  always_comb begin
    out_valid             = ev_r;
    out_data.packed_color = col_r;
    out_data.out_normal_x = eb_r.normal_x;
    out_data.out_normal_y = eb_r.normal_y;
    out_data.out_normal_z = eb_r.normal_z;
    out_data.last_vertex  = (vc_r == tnce_pkg::VC_LAST);
    case (vc_r)
      2'd0: begin
        out_data.pos_x = eb_r.first_x;
        out_data.pos_y = eb_r.first_y;
        out_data.pos_z = eb_r.first_z;
      end
      2'd1: begin
        out_data.pos_x = eb_r.second_x;
        out_data.pos_y = eb_r.second_y;
        out_data.pos_z = eb_r.second_z;
      end
      default: begin
        out_data.pos_x = eb_r.third_x;
        out_data.pos_y = eb_r.third_y;
        out_data.pos_z = eb_r.third_z;
      end
    endcase
  end

endmodule

/* rtl/core/triangle_normal_color_expand_unit.sv */
// Top level of the triangle normal color expand unit
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    tnce_in_t  (one triangle)
//  out_     output     out_valid / out_ready  tnce_out_t (one vertex)
//
// A triangle passes the squaring stage, then the back engine: a load from
// the queue, the square root steps (two digits each), a setup step, the
// divide steps and a handoff to the output register once it is free. The
// engine holds one triangle at a time and loads the next only when idle;
// the three vertices leave while the next triangle is in the engine.
// Reset is synchronous and clears all handshake state.
// A stalled output holds its vertex; the two-entry queue absorbs back engine stalls.
`include "triangle_normal_color_expand_unit_defines.svh"

module triangle_normal_color_expand_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tnce_pkg::tnce_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tnce_pkg::tnce_out_t out_data
);

  logic                 f_valid, f_ready;
  tnce_pkg::tnce_qent_t f_data;
  logic                 b_valid, b_ready;
  tnce_pkg::tnce_qent_t b_data;
  logic                 mid_fire;

  tnce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  tnce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  tnce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_data    (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // vertex transaction that is not the last of its triangle
  assign mid_fire = out_valid && out_ready && !out_data.last_vertex;

  // a triangle keeps presenting vertices until its last one is taken
  `TNCE_ASSERT_NEXT(a_tri_continues, mid_fire, out_valid)
  // all vertices of one triangle share its color
  `TNCE_ASSERT_NEXT(a_color_held, mid_fire, $stable(out_data.packed_color))
  // a squared triangle is not dropped while the queue is full
  `TNCE_ASSERT_NEXT(a_front_held, f_valid && !f_ready, f_valid)
  // alpha channel is always opaque
  `TNCE_ASSERT_SAME(a_alpha, out_valid, out_data.packed_color[31:24] == 8'hFF)

endmodule
